FILE: rtl/rdt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdt_pkg: shared types and constants of the packet deframer and checker
// Header geometry, status codes, the queue entry type and the
// ones'-complement add used by the front end.
// ----------------------------------------------------------------------------
package rdt_pkg;

  localparam int unsigned HDR_BYTES = 9;
  localparam int unsigned CNT_W     = 17;
  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
  localparam logic [15:0] ALL_ONES = 16'hFFFF;

  localparam int unsigned FIFO_DEPTH_DEF = 4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_SHORT    = 2'd1;
  localparam logic [1:0] ST_LEN_MISM = 2'd2;
  localparam logic [1:0] ST_CK_BAD   = 2'd3;

  // One classified input item: a payload result, a closing result, or both.
  typedef struct packed {
    logic        has_pl;
    logic        has_fin;
    logic [7:0]  pl_byte;
    logic [1:0]  status;
    logic [31:0] seq_number;
    logic [7:0]  flag_bits;
    logic [15:0] checksum_field;
    logic [15:0] payload_len;
  } entry_t;

  // 16-bit add with end-around carry.
  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] w);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, w};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

FILE: rtl/rdt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdt_in_if / rdt_out_if: byte input and result channels
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface rdt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       end_of_packet;

  modport source (output valid, output rx_byte, output end_of_packet, input ready);
  modport sink   (input valid, input rx_byte, input end_of_packet, output ready);
endinterface

interface rdt_out_if;
  logic        valid;
  logic        ready;
  logic        is_final;
  logic [7:0]  payload_byte;
  logic [1:0]  status;
  logic [31:0] seq_number;
  logic [7:0]  flag_bits;
  logic [15:0] checksum_field;
  logic [15:0] payload_len;

  modport source (output valid, output is_final, output payload_byte, output status,
                  output seq_number, output flag_bits, output checksum_field,
                  output payload_len, input ready);
  modport sink   (input valid, input is_final, input payload_byte, input status,
                  input seq_number, input flag_bits, input checksum_field,
                  input payload_len, output ready);
endinterface

FILE: rtl/rdt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdt_front: header parse and checksum front end
// Takes one byte per cycle unless the queue is full; keeps header fields,
// byte count, running ones'-complement sum; classifies bytes to queue entries.
// ----------------------------------------------------------------------------
module rdt_front import rdt_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_ready,
  input  logic [7:0] in_byte,
  input  logic   in_last,
  input  logic   q_full,
  output logic   q_push,
  output entry_t q_entry
);

  logic [CNT_W-1:0] byte_count_r, byte_count_nxt;
  logic [15:0]      sum_r, sum_nxt;
  logic [7:0]       pend_r, pend_nxt;
  logic [31:0]      seq_r, seq_nxt;
  logic [7:0]       flags_r, flags_nxt;
  logic [15:0]      cksum_r, cksum_nxt;
  logic [15:0]      len_r, len_nxt;
  logic             acc;
  logic             has_pl;
  logic [1:0]       st;

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;
  assign has_pl   = byte_count_r >= CNT_W'(HDR_BYTES);

  always_comb begin
    seq_nxt   = seq_r;
    flags_nxt = flags_r;
    cksum_nxt = cksum_r;
    len_nxt   = len_r;
    case (byte_count_r)
      17'd0:   seq_nxt[31:24]  = in_byte;
      17'd1:   seq_nxt[23:16]  = in_byte;
      17'd2:   seq_nxt[15:8]   = in_byte;
      17'd3:   seq_nxt[7:0]    = in_byte;
      17'd4:   flags_nxt       = in_byte;
      17'd5:   cksum_nxt[15:8] = in_byte;
      17'd6:   cksum_nxt[7:0]  = in_byte;
      17'd7:   len_nxt[15:8]   = in_byte;
      17'd8:   len_nxt[7:0]    = in_byte;
      default: ;
    endcase

    // Even positions open a byte pair; a lone final byte is padded with zero.
    pend_nxt = pend_r;
    sum_nxt  = sum_r;
    if (!byte_count_r[0]) begin
      pend_nxt = in_byte;
      if (in_last) sum_nxt = oc_add(sum_r, {in_byte, 8'd0});
    end else begin
      sum_nxt = oc_add(sum_r, {pend_r, in_byte});
    end

    byte_count_nxt = (byte_count_r == COUNT_MAX) ? byte_count_r : byte_count_r + 1'b1;

    if (byte_count_nxt < CNT_W'(HDR_BYTES))
      st = ST_SHORT;
    else if ({1'b0, len_nxt} != byte_count_nxt - CNT_W'(HDR_BYTES))
      st = ST_LEN_MISM;
    else if (sum_nxt != ALL_ONES)
      st = ST_CK_BAD;
    else
      st = ST_OK;
  end

  always_comb begin
    q_entry.has_pl         = has_pl;
    q_entry.has_fin        = in_last;
    q_entry.pl_byte        = in_byte;
    q_entry.status         = st;
    q_entry.seq_number     = seq_nxt;
    q_entry.flag_bits      = flags_nxt;
    q_entry.checksum_field = cksum_nxt;
    q_entry.payload_len    = len_nxt;
  end

  assign q_push = acc && (has_pl || in_last);

  always_ff @(posedge clk) begin
    if (!rst_n || (acc && in_last)) begin
      byte_count_r <= '0;
      sum_r        <= '0;
      pend_r       <= '0;
      seq_r        <= '0;
      flags_r      <= '0;
      cksum_r      <= '0;
      len_r        <= '0;
    end else if (acc) begin
      byte_count_r <= byte_count_nxt;
      sum_r        <= sum_nxt;
      pend_r       <= pend_nxt;
      seq_r        <= seq_nxt;
      flags_r      <= flags_nxt;
      cksum_r      <= cksum_nxt;
      len_r        <= len_nxt;
    end
  end

  a_eop_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_last) |=> (byte_count_r == '0 && sum_r == '0))
    else $error("packet state not cleared after last byte");

endmodule

FILE: rtl/rdt_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdt_queue: entry queue between front and back end
// Small register FIFO of classified entries; lets the two ends stall apart.
// ----------------------------------------------------------------------------
module rdt_queue import rdt_pkg::*; #(
  parameter int unsigned DEPTH = FIFO_DEPTH_DEF
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t wr_entry,
  output logic   full,
  input  logic   pop,
  output logic   not_empty,
  output entry_t rd_entry
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  entry_t          q_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   cnt_r;

  assign full      = (cnt_r == CW'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign rd_entry  = q_r[rd_ptr_r];

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) q_r[wr_ptr_r] <= wr_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("queue read while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("queue count out of range");

endmodule

FILE: rtl/rdt_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdt_back: result issue back end
// Holds one queue entry and issues its payload result, then its closing
// result, one per cycle while the output channel is ready.
// ----------------------------------------------------------------------------
module rdt_back import rdt_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   q_not_empty,
  input  entry_t q_entry,
  output logic   q_pop,
  rdt_out_if.source out_if
);

  entry_t ent_r, ent_nxt;
  logic   need_pl_r, need_pl_nxt;
  logic   need_fin_r, need_fin_nxt;
  logic   busy;
  logic   out_acc;
  logic   done;

  assign busy    = need_pl_r || need_fin_r;
  assign out_acc = busy && out_if.ready;
  // The entry retires with this result unless a closing result still follows.
  assign done    = out_acc && !(need_pl_r && need_fin_r);
  assign q_pop   = q_not_empty && (!busy || done);

  always_comb begin
    ent_nxt      = ent_r;
    need_pl_nxt  = need_pl_r;
    need_fin_nxt = need_fin_r;
    if (q_pop) begin
      ent_nxt      = q_entry;
      need_pl_nxt  = q_entry.has_pl;
      need_fin_nxt = q_entry.has_fin;
    end else if (done) begin
      need_pl_nxt  = 1'b0;
      need_fin_nxt = 1'b0;
    end else if (out_acc) begin
      need_pl_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      need_pl_r  <= 1'b0;
      need_fin_r <= 1'b0;
    end else begin
      need_pl_r  <= need_pl_nxt;
      need_fin_r <= need_fin_nxt;
    end
  end

  assign out_if.valid          = busy;
  assign out_if.is_final       = !need_pl_r;
  assign out_if.payload_byte   = need_pl_r ? ent_r.pl_byte : 8'd0;
  assign out_if.status         = need_pl_r ? ST_OK : ent_r.status;
  assign out_if.seq_number     = ent_r.seq_number;
  assign out_if.flag_bits      = ent_r.flag_bits;
  assign out_if.checksum_field = ent_r.checksum_field;
  assign out_if.payload_len    = ent_r.payload_len;

  a_split_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && need_pl_r && need_fin_r) |=> (need_fin_r && !need_pl_r))
    else $error("closing result lost after payload result");

endmodule

FILE: rtl/rdt_packet_deframer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdt_packet_deframer_checker: packet header parser and checksum checker
// Path: a byte's result is registered in the entry queue, then in the back
// end's entry register, before it is valid on the output.
// Throughput: 1 byte per cycle while the queue has room; a last byte that is
// also payload issues two results in turn, absorbed by the entry queue.
// Input rate is set by queue space, output rate by one result per ready cycle.
// Synchronous active-low reset clears all packet state and the queue.
// ----------------------------------------------------------------------------
module rdt_packet_deframer_checker import rdt_pkg::*; #(
  parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  rdt_in_if.sink    in_if,
  rdt_out_if.source out_if
);

  logic   q_push;
  logic   q_full;
  logic   q_pop;
  logic   q_not_empty;
  entry_t wr_entry;
  entry_t rd_entry;

  rdt_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .in_byte  (in_if.rx_byte),
    .in_last  (in_if.end_of_packet),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (wr_entry)
  );

  rdt_queue #(.DEPTH(FIFO_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wr_entry  (wr_entry),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .rd_entry  (rd_entry)
  );

  rdt_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_entry     (rd_entry),
    .q_pop       (q_pop),
    .out_if      (out_if)
  );

endmodule
